// ===== rtl/ilst_pkg.sv =====
// ----------------------------------------------------------------------------
// ilst_pkg: shared types and constants of the indexed list unit
// Command and status codes, data width and default capacity.
// ----------------------------------------------------------------------------
`default_nettype none

package ilst_pkg;

    localparam int DATA_W       = 32;
    localparam int CAPACITY_DEF = 16;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_REMOVE = 2'd1;
    localparam mode_t MODE_PEEK   = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/ilst_ram.sv =====
// ----------------------------------------------------------------------------
// ilst_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/ilst_idx_unit.sv =====
// ----------------------------------------------------------------------------
// ilst_idx_unit: shared index step and bound compare
// Steps the walk index up or down and tells whether the walk continues.
// ----------------------------------------------------------------------------
`default_nettype none

module ilst_idx_unit
    import ilst_pkg::*;
#(
    parameter int CNT_W = 5
) (
    input  wire logic [CNT_W-1:0] idx,
    input  wire logic [CNT_W-1:0] bound,
    input  wire logic             dir_up,
    output logic      [CNT_W-1:0] idx_adj,
    output logic                  go
);

    always_comb
    begin
        if (dir_up)
        begin
            idx_adj = idx + CNT_W'(1);
            go      = (idx_adj < bound);
        end
        else
        begin
            idx_adj = idx - CNT_W'(1);
            go      = (idx > bound);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/indexed_list_insert_remove_peek_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_peek_unit: ordered list with indexed commands
// Insert after a position, remove at a position, peek at a position.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   command  | start, busy            | mode, item_value, position
//   result   | done (one-cycle pulse) | result_value, status, entry_count
//
// Insert and remove shift entries one at a time: each move is a read then
// a write through the single list RAM port pair.
// Reset clears the length register and control; list contents are not cleared.
// Results come out for one cycle with done; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_remove_peek_unit
    import ilst_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    mode,
    input  wire logic signed [DATA_W-1:0]      item_value,
    input  wire logic [$clog2(CAPACITY)-1:0]   position,
    output logic                               done,
    output logic signed [DATA_W-1:0]           result_value,
    output logic [1:0]                         status,
    output logic [$clog2(CAPACITY+1)-1:0]      entry_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_GOT    = 7'b0000100,
        S_RD     = 7'b0001000,
        S_WR     = 7'b0010000,
        S_PUT    = 7'b0100000,
        S_PEEK   = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         slot_reg, slot_next;
    mode_t                    mode_reg, mode_next;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [DATA_W-1:0]        got_reg, got_next;
    logic                     done_reg, done_next;
    logic [DATA_W-1:0]        res_reg, res_next;
    status_t                  status_reg, status_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic [CNT_W-1:0]         pos_ext;
    logic [CNT_W-1:0]         bound;
    logic [CNT_W-1:0]         k_adj;
    logic                     go;
    logic                     dir_up;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [AW-1:0]            rd_addr;
    logic [DATA_W-1:0]        rd_data;

    assign pos_ext = CNT_W'(pos_reg);
    assign dir_up  = (mode_reg == MODE_REMOVE);
    assign bound   = dir_up ? len_reg : slot_reg;

    ilst_idx_unit #(
        .CNT_W (CNT_W)
    ) u_idx (
        .idx     (k_reg),
        .bound   (bound),
        .dir_up  (dir_up),
        .idx_adj (k_adj),
        .go      (go)
    );

    ilst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        slot_next   = slot_reg;
        mode_next   = mode_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        got_next    = got_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        status_next = status_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        wr_addr     = k_reg[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = k_adj[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    value_next = item_value;
                    pos_next   = position;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rd_addr    = pos_reg;
                state_next = S_IDLE;
                done_next  = 1'b1;
                res_next   = '0;
                count_next = len_reg;
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        if (len_reg >= CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (len_reg != '0 && pos_ext >= len_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            slot_next  = (len_reg == '0) ? '0 : pos_ext + CNT_W'(1);
                            k_next     = len_reg;
                            state_next = S_RD;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (pos_ext >= len_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_GOT;
                        end
                    end
                    MODE_PEEK:
                    begin
                        if (pos_ext >= len_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_PEEK;
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
            end
            S_PEEK:
            begin
                done_next   = 1'b1;
                res_next    = rd_data;
                status_next = ST_OK;
                count_next  = len_reg;
                state_next  = S_IDLE;
            end
            S_GOT:
            begin
                got_next   = rd_data;
                k_next     = pos_ext;
                state_next = S_RD;
            end
            S_RD:
            begin
                if (go)
                begin
                    state_next = S_WR;
                end
                else if (dir_up)
                begin
                    len_next    = len_reg - CNT_W'(1);
                    done_next   = 1'b1;
                    res_next    = got_reg;
                    status_next = ST_OK;
                    count_next  = len_reg - CNT_W'(1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_WR:
            begin
                wr_en      = 1'b1;
                k_next     = k_adj;
                state_next = S_RD;
            end
            S_PUT:
            begin
                wr_en       = 1'b1;
                wr_addr     = slot_reg[AW-1:0];
                wr_data     = value_reg;
                len_next    = len_reg + CNT_W'(1);
                done_next   = 1'b1;
                res_next    = '0;
                status_next = ST_OK;
                count_next  = len_reg + CNT_W'(1);
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        slot_reg   <= slot_next;
        mode_reg   <= mode_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        got_reg    <= got_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        count_reg  <= count_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = res_reg;
    assign status       = status_reg;
    assign entry_count  = count_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a command is still running");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

endmodule

`default_nettype wire
